/* rtl/newton_divided_difference_interp_unit_defines.svh */
// Assertion macros used by the checker of the interpolation unit.
`ifndef NEWTON_DIVIDED_DIFFERENCE_INTERP_UNIT_DEFINES_SVH
`define NEWTON_DIVIDED_DIFFERENCE_INTERP_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define NDDI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define NDDI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/nddi_pkg.sv */
`default_nettype none
package nddi_pkg;

   localparam int Q_W   = 32;
   localparam int NP_W  = 6;
   localparam int OUT_W = 7;

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh80000000;

   localparam logic [NP_W-1:0]       NUM_POINTS_RST = 6'd2;
   localparam logic [OUT_W-1:0]      OUT_COUNT_RST  = 7'd2;
   localparam logic signed [Q_W-1:0] X_START_RST    = 32'sd0;
   localparam logic signed [Q_W-1:0] X_END_RST      = 32'sd65536;

   typedef enum logic [1:0] {
      CSR_NUM_POINTS = 2'd0,
      CSR_OUT_COUNT  = 2'd1,
      CSR_X_START    = 2'd2,
      CSR_X_END      = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LVL,
      S_QDIV,
      S_SGO,
      S_STEP,
      S_HSTART,
      S_HSEEK,
      S_HMUL,
      S_HADD,
      S_OUT
   } state_type;

   // One table entry: abscissa, the abscissa a level back, and the coefficient.
   typedef struct packed {
      logic signed [Q_W-1:0] x;
      logic signed [Q_W-1:0] xs;
      logic signed [Q_W-1:0] c;
   } entry_type;

   typedef struct packed {
      logic load;
      logic fwd;
      logic bwd;
   } cell_ctl_type;

   function automatic logic signed [Q_W-1:0] sat_wide(input logic signed [63:0] v);
      logic signed [Q_W-1:0] r;
      if (v > 64'(Q_MAX)) begin
         r = Q_MAX;
      end else if (v < 64'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/nddi_if.sv */
`default_nettype none
interface nddi_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_x;
   logic signed [31:0] sample_y;
   modport source (output valid, output sample_x, output sample_y, input ready);
   modport sink (input valid, input sample_x, input sample_y, output ready);
endinterface

interface nddi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic               is_last;
   logic               div_error;
   modport source (output valid, output out_x, output out_y, output is_last,
                   output div_error, input ready);
   modport sink (input valid, input out_x, input out_y, input is_last,
                 input div_error, output ready);
endinterface
`default_nettype wire

/* rtl/newton_divided_difference_interp_unit.sv */
// Newton divided-difference interpolation unit, signed Q16.16 fixed point.
// Samples arrive as words on req_chan (sample_x, sample_y). The num_points-th
// sample of a run closes it: the unit builds the divided-difference table in
// place, then evaluates the polynomial by Horner's rule at out_count evenly
// spaced abscissas from x_start to x_end and sends one rsp_chan word per point
// (out_x, out_y, is_last on the final one, div_error if a divisor was zero).
// The csr_ port writes the four registers and is meant to be used while idle.
// Closing a run builds (n-1) table levels of MAX_POINTS ring shifts each,
// with one divide on the shared serial divider per table entry with a nonzero
// divisor, plus one divide for the step. Each output point then goes through
// ring shifts and multiply-add steps before its word is shown.
// The table sits in a ring of MAX_POINTS cells, so a pass always goes once
// around the whole ring; the serial divider sets the table build time.
// Synchronous reset returns the registers to their defaults and drops any run
// in progress. While the receiver stalls, the result word is held unchanged
// and no new sample is taken until the run's last word has been accepted.
`default_nettype none
module newton_divided_difference_interp_unit #(
   parameter int MAX_POINTS  = 32,
   parameter int MAX_OUTPUTS = 64,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   nddi_req_if.sink    req_chan,
   nddi_rsp_if.source  rsp_chan
);
   import nddi_pkg::*;

   localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int NW   = (CW > NP_W) ? CW : NP_W;
   localparam int DIVW = 33 + FRAC_BITS;

   // Configuration registers.
   logic [NP_W-1:0]       num_points_ff;
   logic [OUT_W-1:0]      out_count_ff;
   logic signed [Q_W-1:0] x_start_ff;
   logic signed [Q_W-1:0] x_end_ff;

   state_type state_ff, state_in;

   logic [CW-1:0]         loaded_ff;
   logic [CW-1:0]         j_ff;
   logic [IW-1:0]         r_ff;
   logic [IW-1:0]         hk_ff;
   logic [OUT_W-1:0]      i_ff;
   logic                  err_ff;
   logic signed [Q_W-1:0] last_x_ff;
   logic signed [Q_W-1:0] prev_c_ff;
   logic signed [Q_W-1:0] prev_xs_ff;
   logic signed [Q_W-1:0] p_ff;
   logic signed [Q_W-1:0] dx_ff;
   logic signed [63:0]    prod_ff;
   logic signed [32:0]    step_ff;
   logic signed [40:0]    acc_ff;

   entry_type    cell_data [MAX_POINTS];
   entry_type    head;
   entry_type    load_data;
   entry_type    wrap_data;
   cell_ctl_type ctl;

   logic [NW-1:0]         n_eff;
   logic [OUT_W-1:0]      m_eff;
   logic                  run_end;
   logic                  proc;
   logic                  lvl_end;
   logic                  last_level;
   logic signed [Q_W-1:0] num_w;
   logic signed [Q_W-1:0] den_w;
   logic                  den_zero;
   logic signed [Q_W-1:0] qz;
   logic signed [Q_W-1:0] c_new;
   logic                  hk_top;
   logic                  hk_below;
   logic                  hk_zero;
   logic [IW-1:0]         hk_dec;
   logic signed [Q_W-1:0] xv;
   logic signed [Q_W-1:0] prod_t;
   logic signed [Q_W-1:0] p_new;
   logic                  is_last;
   logic                  req_fire;
   logic                  rsp_fire;

   logic                   div_start;
   logic signed [DIVW-1:0] div_dividend;
   logic signed [32:0]     div_divisor;
   logic                   div_done;
   logic signed [DIVW-1:0] div_q;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= NUM_POINTS_RST;
         out_count_ff  <= OUT_COUNT_RST;
         x_start_ff    <= X_START_RST;
         x_end_ff      <= X_END_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_POINTS: num_points_ff <= csr_wdata[NP_W-1:0];
            CSR_OUT_COUNT:  out_count_ff  <= csr_wdata[OUT_W-1:0];
            CSR_X_START:    x_start_ff    <= csr_wdata;
            CSR_X_END:      x_end_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective run sizes after clamping.
   always_comb begin
      if (num_points_ff == '0) begin
         n_eff = NW'(1);
      end else if (NW'(num_points_ff) > NW'(MAX_POINTS)) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = NW'(num_points_ff);
      end
      if (out_count_ff < OUT_W'(2)) begin
         m_eff = OUT_W'(2);
      end else if (out_count_ff > OUT_W'(MAX_OUTPUTS)) begin
         m_eff = OUT_W'(MAX_OUTPUTS);
      end else begin
         m_eff = out_count_ff;
      end
   end

   assign head     = cell_data[0];
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign run_end  = (NW'(loaded_ff) + NW'(1)) >= n_eff;

   // Table build: the head cell holds entry r of the forward-rotating ring.
   assign proc       = (NW'(r_ff) >= NW'(j_ff)) && (NW'(r_ff) < n_eff);
   assign lvl_end    = r_ff == IW'(MAX_POINTS - 1);
   assign last_level = (NW'(j_ff) + NW'(1)) == n_eff;
   assign num_w      = sat_wide(64'(head.c) - 64'(prev_c_ff));
   assign den_w      = sat_wide(64'(head.x) - 64'(head.xs));
   assign den_zero   = den_w == '0;

   always_comb begin
      if (num_w > 0) begin
         qz = Q_MAX;
      end else if (num_w < 0) begin
         qz = Q_MIN;
      end else begin
         qz = '0;
      end
      if (state_ff == S_QDIV) begin
         c_new = sat_wide(64'(div_q));
      end else if (proc) begin
         c_new = qz;
      end else begin
         c_new = head.c;
      end
   end

   // The entry leaving the head carries its new coefficient and the abscissa
   // it needs on the next level.
   assign wrap_data = '{x: head.x, xs: prev_xs_ff, c: c_new};
   assign load_data = '{x: req_chan.sample_x, xs: last_x_ff, c: req_chan.sample_y};

   // Horner: the head cell holds entry hk of the backward-rotating ring.
   assign hk_top   = NW'(hk_ff) == (n_eff - NW'(1));
   assign hk_below = NW'(hk_ff) < (n_eff - NW'(1));
   assign hk_zero  = hk_ff == '0;
   assign hk_dec   = hk_zero ? IW'(MAX_POINTS - 1) : hk_ff - IW'(1);
   assign xv       = sat_wide(64'(acc_ff));
   assign prod_t   = sat_wide(prod_ff >>> FRAC_BITS);
   assign p_new    = sat_wide(64'(head.c) + 64'(prod_t));
   assign is_last  = i_ff == (m_eff - OUT_W'(1));

   // Shared divider: table quotients, or the abscissa step.
   always_comb begin
      if (state_ff == S_SGO) begin
         div_dividend = DIVW'(33'(x_end_ff) - 33'(x_start_ff));
         div_divisor  = 33'(m_eff - OUT_W'(1));
      end else begin
         div_dividend = DIVW'(num_w) <<< FRAC_BITS;
         div_divisor  = 33'(den_w);
      end
   end

   nddi_div #(
      .DIVW (DIVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // Ring of cells.
   for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
      entry_type fwd_src;
      entry_type bwd_src;
      logic      sel;
      if (k == MAX_POINTS - 1) begin : g_fwd_wrap
         assign fwd_src = wrap_data;
      end else begin : g_fwd_next
         assign fwd_src = cell_data[k + 1];
      end
      if (k == 0) begin : g_bwd_wrap
         assign bwd_src = cell_data[MAX_POINTS - 1];
      end else begin : g_bwd_prev
         assign bwd_src = cell_data[k - 1];
      end
      assign sel = NW'(k) == NW'(loaded_ff);
      nddi_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_sel  (sel),
         .load_data (load_data),
         .fwd_data  (fwd_src),
         .bwd_data  (bwd_src),
         .data      (cell_data[k])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && run_end) begin
               state_in = (n_eff == NW'(1)) ? S_SGO : S_LVL;
            end
         end
         S_LVL: begin
            if (proc && !den_zero) begin
               state_in = S_QDIV;
            end else if (lvl_end && last_level) begin
               state_in = S_SGO;
            end
         end
         S_QDIV: begin
            if (div_done) begin
               state_in = (lvl_end && last_level) ? S_SGO : S_LVL;
            end
         end
         S_SGO: state_in = S_STEP;
         S_STEP: begin
            if (div_done) begin
               state_in = S_HSTART;
            end
         end
         S_HSTART: state_in = S_HSEEK;
         S_HSEEK: begin
            if (hk_below) begin
               state_in = S_HMUL;
            end else if (hk_zero) begin
               state_in = S_OUT;
            end
         end
         S_HMUL: state_in = S_HADD;
         S_HADD: state_in = hk_zero ? S_OUT : S_HSEEK;
         S_OUT: begin
            if (rsp_fire) begin
               state_in = is_last ? S_IDLE : S_HSTART;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs. The step on entry zero does not rotate the ring, so a
   // point ends with entry zero back at the head and the next one starts there.
   always_comb begin
      req_chan.ready = state_ff == S_IDLE;
      rsp_chan.valid = state_ff == S_OUT;
      div_start      = ((state_ff == S_LVL) && proc && !den_zero) || (state_ff == S_SGO);
      ctl.load       = (state_ff == S_IDLE) && req_chan.valid;
      ctl.fwd        = ((state_ff == S_LVL) && !(proc && !den_zero)) ||
                       ((state_ff == S_QDIV) && div_done);
      ctl.bwd        = (state_ff == S_HSTART) ||
                       ((state_ff == S_HSEEK) && !hk_below && !hk_zero) ||
                       ((state_ff == S_HADD) && !hk_zero);
   end

   assign rsp_chan.out_x     = xv;
   assign rsp_chan.out_y     = p_ff;
   assign rsp_chan.is_last   = is_last;
   assign rsp_chan.div_error = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         loaded_ff <= '0;
         err_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            if (run_end) begin
               loaded_ff <= '0;
               err_ff    <= 1'b0;
            end else begin
               loaded_ff <= loaded_ff + CW'(1);
            end
         end
         if ((state_ff == S_LVL) && proc && den_zero) begin
            err_ff <= 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         last_x_ff <= req_chan.sample_x;
         j_ff      <= CW'(1);
         r_ff      <= '0;
      end
      if (ctl.fwd) begin
         prev_c_ff  <= head.c;
         prev_xs_ff <= head.xs;
         r_ff       <= lvl_end ? '0 : r_ff + IW'(1);
         if (lvl_end) begin
            j_ff <= j_ff + CW'(1);
         end
      end
      case (state_ff)
         S_STEP: begin
            if (div_done) begin
               step_ff <= div_q[32:0];
               acc_ff  <= 41'(x_start_ff);
               i_ff    <= '0;
            end
         end
         S_HSTART: hk_ff <= IW'(MAX_POINTS - 1);
         S_HSEEK: begin
            if (hk_below) begin
               dx_ff <= sat_wide(64'(xv) - 64'(head.x));
            end else begin
               if (hk_top) begin
                  p_ff <= head.c;
               end
               hk_ff <= hk_dec;
            end
         end
         S_HMUL: prod_ff <= dx_ff * p_ff;
         S_HADD: begin
            p_ff  <= p_new;
            hk_ff <= hk_dec;
         end
         S_OUT: begin
            if (rsp_fire && !is_last) begin
               i_ff   <= i_ff + OUT_W'(1);
               acc_ff <= acc_ff + 41'(step_ff);
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/nddi_cell.sv */
`default_nettype none
module nddi_cell (
   input  logic                 clock,
   input  nddi_pkg::cell_ctl_type ctl,
   input  logic                 load_sel,
   input  nddi_pkg::entry_type  load_data,
   input  nddi_pkg::entry_type  fwd_data,
   input  nddi_pkg::entry_type  bwd_data,
   output nddi_pkg::entry_type  data
);
   import nddi_pkg::*;

   entry_type data_ff;

   // A sample write wins; otherwise the ring shifts one way or the other.
   always_ff @(posedge clock) begin
      if (ctl.load && load_sel) begin
         data_ff <= load_data;
      end else if (ctl.fwd) begin
         data_ff <= fwd_data;
      end else if (ctl.bwd) begin
         data_ff <= bwd_data;
      end
   end

   assign data = data_ff;

endmodule
`default_nettype wire

/* rtl/nddi_div.sv */
`default_nettype none
module nddi_div #(
   parameter int DIVW = 49
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [DIVW-1:0] dividend,
   input  logic signed [32:0]     divisor,
   output logic                   done,
   output logic signed [DIVW-1:0] quotient
);
   import nddi_pkg::*;

   localparam int CNT_W = $clog2(DIVW + 1);

   logic [DIVW-1:0]  dnd_ff;
   logic [32:0]      dvs_ff;
   logic [32:0]      rem_ff;
   logic             neg_ff;
   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [33:0]      rem_sh;
   logic             fits;

   // Restoring division on magnitudes, one quotient bit per cycle.
   assign rem_sh = {rem_ff, dnd_ff[DIVW-1]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(DIVW);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dnd_ff <= dividend[DIVW-1] ? DIVW'(-dividend) : DIVW'(dividend);
         dvs_ff <= divisor[32] ? 33'(-divisor) : 33'(divisor);
         neg_ff <= dividend[DIVW-1] ^ divisor[32];
         rem_ff <= '0;
      end else if (run_ff) begin
         rem_ff <= fits ? 33'(rem_sh - {1'b0, dvs_ff}) : rem_sh[32:0];
         dnd_ff <= {dnd_ff[DIVW-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(dnd_ff) : $signed(dnd_ff);

endmodule
`default_nettype wire

/* rtl/nddi_checker.sv */
`default_nettype none
`include "newton_divided_difference_interp_unit_defines.svh"
module nddi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_last,
   input logic [31:0] rsp_out_x,
   input logic [31:0] rsp_out_y
);

   // A stalled result word stays put.
   `NDDI_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y), "result word changed while stalled")

   // No sample is taken while results of a run are still going out.
   `NDDI_ASSERT(a_no_overlap, clock, reset, rsp_valid |-> !(req_valid && req_ready), "sample accepted during result output")

   // The last word of a run returns the unit to taking samples.
   `NDDI_ASSERT(a_last_ends, clock, reset, rsp_valid && rsp_ready && rsp_is_last |=> !rsp_valid && req_ready, "run did not end after last word")

   // Reset drops any pending result.
   `NDDI_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind newton_divided_difference_interp_unit nddi_checker u_nddi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_is_last (rsp_chan.is_last),
   .rsp_out_x   (rsp_chan.out_x),
   .rsp_out_y   (rsp_chan.out_y)
);
`default_nettype wire
